/* design/mkrc_pkg.sv */
`default_nettype none
package mkrc_pkg;

  typedef enum logic [1:0] {
    ACT_SCAN  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_ACK   = 2'd3
  } action_t;

  localparam logic [2:0] SEL_KEY_STATE = 3'd0;
  localparam logic [2:0] SEL_KEY_CODE  = 3'd1;
  localparam logic [2:0] SEL_SCROLL    = 3'd2;
  localparam logic [2:0] SEL_KEY_PRESS = 3'd3;
  localparam logic [2:0] SEL_FDC_CMD   = 3'd4;
  localparam logic [2:0] SEL_FDC_DATA  = 3'd5;

  localparam logic [7:0]  VEC_LOW      = 8'h30;
  localparam logic [7:0]  VEC_HIGH     = 8'hBC;
  localparam logic [15:0] STATUS_BASE  = 16'h8080;
  localparam logic [15:0] SCROLL_RESET = 16'o1330;
  localparam logic [6:0]  SHIFT_DOWN   = 7'd16;
  localparam logic [6:0]  SHIFT_UP     = 7'd32;
  localparam logic signed [2:0] NO_DRIVE = -3'sd1;

  localparam int NUM_ROWS = 11;

  typedef struct packed {
    logic       hit;
    logic [3:0] row;
    logic       one_hot;
    logic [2:0] col;
  } scan_res_t;

endpackage
`default_nettype wire

/* design/mkrc_if.sv */
`default_nettype none
interface mkrc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  reg_select;
  logic [15:0] write_data;
  logic [63:0] rows_one_to_eight;
  logic [23:0] rows_nine_to_eleven;
  logic        shift_held;
  logic        vector_key;
  logic        cassette_in;

  modport source (
    output valid, action, reg_select, write_data, rows_one_to_eight,
           rows_nine_to_eleven, shift_held, vector_key, cassette_in,
    input  ready
  );
  modport sink (
    input  valid, action, reg_select, write_data, rows_one_to_eight,
           rows_nine_to_eleven, shift_held, vector_key, cassette_in,
    output ready
  );
endinterface

interface mkrc_out_if;
  logic              valid;
  logic              ready;
  logic [15:0]       read_data;
  logic              irq_line;
  logic              cassette_out;
  logic signed [2:0] drive_select;

  modport source (
    output valid, read_data, irq_line, cassette_out, drive_select,
    input  ready
  );
  modport sink (
    input  valid, read_data, irq_line, cassette_out, drive_select,
    output ready
  );
endinterface
`default_nettype wire

/* design/mkrc_scan.sv */
`default_nettype none
module mkrc_scan
  import mkrc_pkg::*;
(
  input  wire logic [63:0] rows_lo,
  input  wire logic [23:0] rows_hi,
  output scan_res_t        res
);

  logic [7:0] row_byte [NUM_ROWS];
  logic [7:0] sel_byte;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      row_byte[i] = rows_lo[8*i +: 8];
    end
    for (int i = 0; i < 3; i++) begin
      row_byte[8+i] = rows_hi[8*i +: 8];
    end
  end

  // first nonzero row wins, scan from the top down so row 1 has priority
  always_comb begin
    res.hit  = 1'b0;
    res.row  = 4'd0;
    sel_byte = 8'd0;
    for (int i = NUM_ROWS - 1; i >= 0; i--) begin
      if (row_byte[i] != 8'd0) begin
        res.hit  = 1'b1;
        res.row  = 4'(i + 1);
        sel_byte = row_byte[i];
      end
    end
    res.one_hot = $onehot(sel_byte);
    res.col     = 3'd0;
    for (int c = 0; c < 8; c++) begin
      if (sel_byte[c]) begin
        res.col = 3'(c);
      end
    end
  end

endmodule
`default_nettype wire

/* design/matrix_keyboard_register_controller.sv */
// path: input transfer lands in the input register, then in the result register
// throughput: one item per cycle if the sink is ready, each in one pass through the update logic
// while a result waits the input register still takes one item, then the input stalls
// reset: synchronous active-low rst_n; clears both valid flags and all register-file state,
// scroll register comes up at octal 1330 and the drive select at -1 (no drive)
`default_nettype none
module matrix_keyboard_register_controller
  import mkrc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  mkrc_in_if.sink    in_chan,
  mkrc_out_if.source out_chan
);

  // input register
  logic        s1_v_r;
  action_t     s1_act_r;
  logic [2:0]  s1_sel_r;
  logic [15:0] s1_wd_r;
  logic [63:0] s1_lo_r;
  logic [23:0] s1_hi_r;
  logic        s1_shift_r;
  logic        s1_vkey_r;
  logic        s1_cas_r;

  // result register
  logic              out_v_r;
  logic [15:0]       out_rd_r;
  logic [15:0]       out_rd_nxt;

  // architectural state
  logic [6:0]        key_code_r,    key_code_nxt;
  logic              key_pressed_r, key_pressed_nxt;
  logic [7:0]        vector_r,      vector_nxt;
  logic              irq_r,         irq_nxt;
  logic              state_b6_r,    state_b6_nxt;
  logic [15:0]       scroll_r,      scroll_nxt;
  logic              cas_level_r,   cas_level_nxt;
  logic signed [2:0] drive_r,       drive_nxt;

  logic      adv;
  logic      fire;
  scan_res_t scan;
  logic [6:0] base_code;

  // the result register drains or is empty: the input register may move on
  assign adv          = !out_v_r || out_chan.ready;
  assign fire         = s1_v_r && adv;
  assign in_chan.ready = !s1_v_r || adv;

  assign out_chan.valid        = out_v_r;
  assign out_chan.read_data    = out_rd_r;
  assign out_chan.irq_line     = irq_r;
  assign out_chan.cassette_out = cas_level_r;
  assign out_chan.drive_select = drive_r;

  mkrc_scan u_scan (
    .rows_lo (s1_lo_r),
    .rows_hi (s1_hi_r),
    .res     (scan)
  );

  // one-hot row gives {row, col}; otherwise the old code is kept and still shifted
  assign base_code = scan.one_hot ? {scan.row, scan.col} : key_code_r;

  always_comb begin
    key_code_nxt    = key_code_r;
    key_pressed_nxt = key_pressed_r;
    vector_nxt      = vector_r;
    irq_nxt         = irq_r;
    state_b6_nxt    = state_b6_r;
    scroll_nxt      = scroll_r;
    cas_level_nxt   = cas_level_r;
    drive_nxt       = drive_r;
    out_rd_nxt      = 16'd0;

    case (s1_act_r)
      ACT_SCAN: begin
        if (scan.hit) begin
          if (s1_shift_r && (scan.row == 4'd6 || scan.row == 4'd7)) begin
            key_code_nxt = base_code - SHIFT_DOWN;
          end else if (s1_shift_r && scan.row >= 4'd8) begin
            key_code_nxt = base_code + SHIFT_UP;
          end else begin
            key_code_nxt = base_code;
          end
          key_pressed_nxt = 1'b1;
          vector_nxt      = s1_vkey_r ? VEC_HIGH : VEC_LOW;
          irq_nxt         = 1'b1;
        end
      end
      ACT_READ: begin
        case (s1_sel_r)
          SEL_KEY_STATE: out_rd_nxt = {9'd0, state_b6_r, 6'd0};
          SEL_KEY_CODE: begin
            out_rd_nxt      = {9'd0, key_code_r};
            key_pressed_nxt = 1'b0;
          end
          SEL_SCROLL:    out_rd_nxt = scroll_r;
          SEL_KEY_PRESS: out_rd_nxt = STATUS_BASE | {9'd0, key_pressed_r, s1_cas_r, 5'd0};
          default:       out_rd_nxt = 16'd0;
        endcase
      end
      ACT_WRITE: begin
        case (s1_sel_r)
          SEL_KEY_STATE: state_b6_nxt  = s1_wd_r[6];
          SEL_SCROLL:    scroll_nxt    = s1_wd_r;
          SEL_KEY_PRESS: cas_level_nxt = s1_wd_r[6];
          SEL_FDC_CMD: begin
            // highest set bit of the low nibble picks the drive
            if (s1_wd_r == 16'd0)   drive_nxt = NO_DRIVE;
            else if (s1_wd_r[3])    drive_nxt = 3'sd3;
            else if (s1_wd_r[2])    drive_nxt = 3'sd2;
            else if (s1_wd_r[1])    drive_nxt = 3'sd1;
            else if (s1_wd_r[0])    drive_nxt = 3'sd0;
          end
          default: ;
        endcase
      end
      ACT_ACK: begin
        irq_nxt    = 1'b0;
        out_rd_nxt = {8'd0, vector_r};
      end
      default: ;
    endcase
  end

  // input register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_v_r <= in_chan.valid;
    end
  end

  // input register: payload
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_act_r   <= action_t'(in_chan.action);
      s1_sel_r   <= in_chan.reg_select;
      s1_wd_r    <= in_chan.write_data;
      s1_lo_r    <= in_chan.rows_one_to_eight;
      s1_hi_r    <= in_chan.rows_nine_to_eleven;
      s1_shift_r <= in_chan.shift_held;
      s1_vkey_r  <= in_chan.vector_key;
      s1_cas_r   <= in_chan.cassette_in;
    end
  end

  // result register and state update on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r       <= 1'b0;
      key_code_r    <= 7'd0;
      key_pressed_r <= 1'b0;
      vector_r      <= 8'd0;
      irq_r         <= 1'b0;
      state_b6_r    <= 1'b0;
      scroll_r      <= SCROLL_RESET;
      cas_level_r   <= 1'b0;
      drive_r       <= NO_DRIVE;
    end else begin
      if (adv) begin
        out_v_r <= s1_v_r;
      end
      if (fire) begin
        key_code_r    <= key_code_nxt;
        key_pressed_r <= key_pressed_nxt;
        vector_r      <= vector_nxt;
        irq_r         <= irq_nxt;
        state_b6_r    <= state_b6_nxt;
        scroll_r      <= scroll_nxt;
        cas_level_r   <= cas_level_nxt;
        drive_r       <= drive_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rd_r <= out_rd_nxt;
    end
  end

  // an acknowledge transfer always leaves the line low
  a_ack_clears_irq: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_act_r == ACT_ACK |=> !irq_r)
    else $error("irq line still high after acknowledge");

  // a scan hit raises both the pressed flag and the line
  a_hit_sets_flags: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_act_r == ACT_SCAN && scan.hit |=> key_pressed_r && irq_r)
    else $error("scan hit did not set pressed flag and irq");

  // drive select only ever holds -1 or 0..3
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    !(drive_r == 3'sd4 || drive_r == 3'sd5 || drive_r == 3'sd6))
    else $error("drive select out of range");

  // back pressure only when both registers are full and the sink stalls
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> s1_v_r && out_v_r && !out_chan.ready)
    else $error("input stalled without a full pipeline");

  // state only moves when an item passes through
  a_scroll_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(fire) && $past(rst_n) |-> $stable(scroll_r))
    else $error("scroll register changed without a transfer");

endmodule
`default_nettype wire
